// ===== hdl/linear_regression_gradient_descent_core_macros.svh =====
// assertion macros for the gradient descent core
`ifndef LINEAR_REGRESSION_GRADIENT_DESCENT_CORE_MACROS_SVH
`define LINEAR_REGRESSION_GRADIENT_DESCENT_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LRGD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LRGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lrgd_pkg.sv =====
// shared types, constants and saturation helpers for the gradient descent core
package lrgd_pkg;

    localparam int MAX_ROWS_DEF     = 1024;
    localparam int NUM_FEATURES_DEF = 3;
    localparam int LR_W             = 17;
    localparam int EPOCH_W          = 13;
    localparam int DIV_STEPS        = 64;
    localparam logic [LR_W-1:0]    LR_RESET    = LR_W'(655);
    localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(100);

    // update slot: three weights, bias, then mse
    localparam logic [2:0] K_BIAS = 3'd3;
    localparam logic [2:0] K_MSE  = 3'd4;

    typedef struct packed {
        logic signed [31:0] feature_a;
        logic signed [31:0] feature_b;
        logic signed [31:0] feature_c;
        logic signed [31:0] target;
        logic               last_row;
    } row_word_t;

    typedef struct packed {
        logic signed [31:0] weight_a;
        logic signed [31:0] weight_b;
        logic signed [31:0] weight_c;
        logic signed [31:0] bias;
        logic        [31:0] mean_sq_error;
    } result_word_t;

    typedef enum logic [2:0] {
        MUL_XA_WA, MUL_XB_WB, MUL_XC_WC, MUL_XA_E, MUL_XB_E, MUL_XC_E, MUL_E_E, MUL_G_LR
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_A, ACC_B, ACC_C, ACC_SQ
    } acc_sel_t;

    typedef struct packed {
        logic       row_wr;
        logic       row_clr;
        logic       train_clr;
        logic       mem_rd;
        logic       idx_clr;
        logic       idx_inc;
        logic       mul_en;
        mul_sel_t   mul_sel;
        logic       pred_init;
        logic       pred_add;
        logic       err_en;
        acc_sel_t   acc_sel;
        logic       bias_acc;
        logic       acc_clr;
        logic       div_start;
        logic       grad_en;
        logic       upd_en;
        logic [2:0] k;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic div_busy;
        logic div_done;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/lrgd_div.sv =====
// restoring divider, one quotient bit per cycle
module lrgd_div #(
    parameter int CW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [63:0]   dividend,
    input  logic [CW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [63:0]   quot
);
    localparam int NW = $clog2(lrgd_pkg::DIV_STEPS + 1);

    logic [NW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [63:0]   quot_reg, quot_next;
    logic [CW:0]   rem_reg, rem_next;
    logic [CW-1:0] dvs_reg;
    logic [CW:0]   rem_sh;

    always_comb begin
        rem_sh    = {rem_reg[CW-1:0], quot_reg[63]};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start) begin
            cnt_next  = NW'(lrgd_pkg::DIV_STEPS);
            quot_next = dividend;
            rem_next  = '0;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - NW'(1);
            done_next = (cnt_reg == NW'(1));
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next  = rem_sh - {1'b0, dvs_reg};
                quot_next = {quot_reg[62:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                quot_next = {quot_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hdl/lrgd_datapath.sv =====
// row store, shared multiplier, accumulators, weights and result register
module lrgd_datapath #(
    parameter int MAX_ROWS     = lrgd_pkg::MAX_ROWS_DEF,
    parameter int NUM_FEATURES = lrgd_pkg::NUM_FEATURES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lrgd_pkg::dp_cmd_t             cmd,
    input  lrgd_pkg::row_word_t           s_data,
    input  logic [lrgd_pkg::LR_W-1:0]     learning_rate,
    output lrgd_pkg::dp_stat_t            stat,
    output lrgd_pkg::result_word_t        m_data
);
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    lrgd_pkg::row_word_t row_mem [MAX_ROWS];
    lrgd_pkg::row_word_t rd_reg;
    logic [CW-1:0]       row_cnt_reg;
    logic [AW-1:0]       rd_idx_reg;

    logic signed [31:0]  w_reg [3];
    logic signed [31:0]  bias_reg;
    logic signed [31:0]  e_reg;
    logic signed [31:0]  g_reg;
    logic signed [63:0]  pred_reg;
    logic signed [63:0]  prod_reg;
    logic signed [63:0]  acc_reg [4];
    logic        [63:0]  sq_reg;
    logic        [31:0]  mse_reg;
    logic                neg_reg;
    lrgd_pkg::result_word_t out_reg;

    logic signed [31:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [64:0]  mul_full;
    logic signed [31:0]  pred_sat;
    logic signed [31:0]  e_next;
    logic [64:0]         sq_sum;
    logic signed [63:0]  div_src;
    logic [63:0]         div_mag;
    logic [63:0]         quot;
    logic signed [64:0]  quot_s;
    logic signed [63:0]  step;
    logic signed [31:0]  upd_old;
    logic signed [31:0]  upd_new;
    logic                div_busy;
    logic                div_done;

    always_comb begin
        case (cmd.mul_sel)
            lrgd_pkg::MUL_XA_WA: begin mul_a = rd_reg.feature_a; mul_b = 33'(w_reg[0]); end
            lrgd_pkg::MUL_XB_WB: begin mul_a = rd_reg.feature_b; mul_b = 33'(w_reg[1]); end
            lrgd_pkg::MUL_XC_WC: begin mul_a = rd_reg.feature_c; mul_b = 33'(w_reg[2]); end
            lrgd_pkg::MUL_XA_E:  begin mul_a = rd_reg.feature_a; mul_b = 33'(e_reg); end
            lrgd_pkg::MUL_XB_E:  begin mul_a = rd_reg.feature_b; mul_b = 33'(e_reg); end
            lrgd_pkg::MUL_XC_E:  begin mul_a = rd_reg.feature_c; mul_b = 33'(e_reg); end
            lrgd_pkg::MUL_E_E:   begin mul_a = e_reg; mul_b = 33'(e_reg); end
            lrgd_pkg::MUL_G_LR:  begin mul_a = g_reg; mul_b = $signed({16'd0, learning_rate}); end
            default:             begin mul_a = '0; mul_b = '0; end
        endcase
        mul_full = mul_a * mul_b;
    end

    assign pred_sat = lrgd_pkg::sat32(65'(pred_reg));
    assign e_next   = lrgd_pkg::sat32(65'(pred_sat) - 65'(rd_reg.target));
    assign sq_sum   = {1'b0, sq_reg} + {1'b0, prod_reg[63:0]};

    // divide source: signed sums for gradients, unsigned square sum for mse
    assign div_src = acc_reg[cmd.k[1:0]];
    always_comb begin
        if (cmd.k == lrgd_pkg::K_MSE) begin
            div_mag = sq_reg;
        end else if (div_src[63]) begin
            div_mag = 64'(-div_src);
        end else begin
            div_mag = div_src;
        end
    end

    lrgd_div #(.CW(CW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_mag),
        .divisor  (row_cnt_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (quot)
    );

    assign quot_s  = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign step    = prod_reg >>> 16;
    assign upd_old = (cmd.k == lrgd_pkg::K_BIAS) ? bias_reg : w_reg[cmd.k[1:0]];
    assign upd_new = lrgd_pkg::sat32(65'(upd_old) - 65'(step));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
        end else if (cmd.row_clr) begin
            row_cnt_reg <= '0;
        end else if (cmd.row_wr && (row_cnt_reg < CW'(MAX_ROWS))) begin
            row_cnt_reg <= row_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_wr && (row_cnt_reg < CW'(MAX_ROWS))) begin
            row_mem[row_cnt_reg[AW-1:0]] <= s_data;
        end
        if (cmd.mem_rd) begin
            rd_reg <= row_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_clr) begin
            rd_idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            rd_idx_reg <= rd_idx_reg + AW'(1);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_full[63:0];
        end
        if (cmd.pred_init) begin
            pred_reg <= 64'(bias_reg);
        end else if (cmd.pred_add) begin
            pred_reg <= pred_reg + (prod_reg >>> 16);
        end
        if (cmd.err_en) begin
            e_reg <= e_next;
        end
        if (cmd.acc_clr) begin
            for (int j = 0; j < 4; j++) begin
                acc_reg[j] <= '0;
            end
            sq_reg <= '0;
        end else begin
            case (cmd.acc_sel)
                lrgd_pkg::ACC_A:  acc_reg[0] <= lrgd_pkg::sadd64(acc_reg[0], prod_reg);
                lrgd_pkg::ACC_B:  acc_reg[1] <= lrgd_pkg::sadd64(acc_reg[1], prod_reg);
                lrgd_pkg::ACC_C:  acc_reg[2] <= lrgd_pkg::sadd64(acc_reg[2], prod_reg);
                lrgd_pkg::ACC_SQ: sq_reg <= sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];
                default: ;
            endcase
            if (cmd.bias_acc) begin
                acc_reg[3] <= lrgd_pkg::sadd64(acc_reg[3], 64'(e_reg));
            end
        end
        if (cmd.div_start) begin
            neg_reg <= (cmd.k != lrgd_pkg::K_MSE) && div_src[63];
        end
        if (cmd.train_clr) begin
            for (int j = 0; j < 3; j++) begin
                w_reg[j] <= '0;
            end
            bias_reg <= '0;
            mse_reg  <= '0;
        end else begin
            if (cmd.grad_en) begin
                if (cmd.k == lrgd_pkg::K_MSE) begin
                    mse_reg <= (quot[63:48] != '0) ? 32'hffffffff : quot[47:16];
                end else if (cmd.k == lrgd_pkg::K_BIAS) begin
                    g_reg <= lrgd_pkg::sat32(quot_s);
                end else begin
                    g_reg <= lrgd_pkg::sat32(quot_s >>> 16);
                end
            end
            if (cmd.upd_en) begin
                if (cmd.k == lrgd_pkg::K_BIAS) begin
                    bias_reg <= upd_new;
                end else if (32'(cmd.k) < NUM_FEATURES) begin
                    w_reg[cmd.k[1:0]] <= upd_new;
                end
            end
        end
        if (cmd.out_load) begin
            out_reg.weight_a      <= w_reg[0];
            out_reg.weight_b      <= w_reg[1];
            out_reg.weight_c      <= w_reg[2];
            out_reg.bias          <= bias_reg;
            out_reg.mean_sq_error <= mse_reg;
        end
    end

    assign stat.idx_last = ({{(CW-AW){1'b0}}, rd_idx_reg} == (row_cnt_reg - CW'(1)));
    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;
    assign m_data        = out_reg;

endmodule

// ===== hdl/lrgd_ctrl.sv =====
// sequencer for row loading, epochs, per-row steps and parameter updates
module lrgd_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_last,
    input  logic                         m_ready,
    input  logic [lrgd_pkg::EPOCH_W-1:0] epoch_count,
    input  lrgd_pkg::dp_stat_t           stat,
    output logic                         s_ready,
    output logic                         m_valid,
    output lrgd_pkg::dp_cmd_t            cmd
);
    typedef enum logic [4:0] {
        ST_IDLE, ST_EP, ST_RD, ST_M0, ST_M1, ST_M2, ST_M3, ST_ER,
        ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_DS, ST_DW, ST_UM, ST_UP, ST_FIN
    } state_t;

    state_t                       state_reg;
    logic [lrgd_pkg::EPOCH_W-1:0] epoch_reg;
    logic [2:0]                   k_reg;
    logic                         m_valid_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = lrgd_pkg::MUL_XA_WA;
        cmd.acc_sel = lrgd_pkg::ACC_NONE;
        cmd.k       = k_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.row_wr    = s_valid;
                cmd.train_clr = s_valid && s_last;
            end
            ST_EP: begin
                cmd.acc_clr = 1'b1;
                cmd.idx_clr = 1'b1;
            end
            ST_RD: begin
                cmd.mem_rd    = 1'b1;
                cmd.pred_init = 1'b1;
            end
            ST_M0: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = lrgd_pkg::MUL_XA_WA;
            end
            ST_M1: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = lrgd_pkg::MUL_XB_WB; cmd.pred_add = 1'b1;
            end
            ST_M2: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = lrgd_pkg::MUL_XC_WC; cmd.pred_add = 1'b1;
            end
            ST_M3: cmd.pred_add = 1'b1;
            ST_ER: cmd.err_en = 1'b1;
            ST_G0: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = lrgd_pkg::MUL_XA_E;
            end
            ST_G1: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = lrgd_pkg::MUL_XB_E; cmd.acc_sel = lrgd_pkg::ACC_A;
            end
            ST_G2: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = lrgd_pkg::MUL_XC_E; cmd.acc_sel = lrgd_pkg::ACC_B;
            end
            ST_G3: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = lrgd_pkg::MUL_E_E;
                cmd.acc_sel  = lrgd_pkg::ACC_C;
                cmd.bias_acc = 1'b1;
            end
            ST_G4: begin
                cmd.acc_sel = lrgd_pkg::ACC_SQ;
                cmd.idx_inc = !stat.idx_last;
            end
            ST_DS: cmd.div_start = 1'b1;
            ST_DW: cmd.grad_en = stat.div_done;
            ST_UM: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = lrgd_pkg::MUL_G_LR;
            end
            ST_UP: cmd.upd_en = 1'b1;
            ST_FIN: begin
                cmd.out_load = !m_valid_reg;
                cmd.row_clr  = !m_valid_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            epoch_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_last) begin
                        epoch_reg <= '0;
                        state_reg <= ST_EP;
                    end
                end
                ST_EP:   state_reg <= (epoch_reg == epoch_count) ? ST_FIN : ST_RD;
                ST_RD:   state_reg <= ST_M0;
                ST_M0:   state_reg <= ST_M1;
                ST_M1:   state_reg <= ST_M2;
                ST_M2:   state_reg <= ST_M3;
                ST_M3:   state_reg <= ST_ER;
                ST_ER:   state_reg <= ST_G0;
                ST_G0:   state_reg <= ST_G1;
                ST_G1:   state_reg <= ST_G2;
                ST_G2:   state_reg <= ST_G3;
                ST_G3:   state_reg <= ST_G4;
                ST_G4: begin
                    if (stat.idx_last) begin
                        k_reg     <= '0;
                        state_reg <= ST_DS;
                    end else begin
                        state_reg <= ST_RD;
                    end
                end
                ST_DS:   state_reg <= ST_DW;
                ST_DW: begin
                    if (stat.div_done) begin
                        if (k_reg == lrgd_pkg::K_MSE) begin
                            epoch_reg <= epoch_reg + lrgd_pkg::EPOCH_W'(1);
                            state_reg <= ST_EP;
                        end else begin
                            state_reg <= ST_UM;
                        end
                    end
                end
                ST_UM:   state_reg <= ST_UP;
                ST_UP: begin
                    k_reg     <= k_reg + 3'd1;
                    state_reg <= ST_DS;
                end
                ST_FIN: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/linear_regression_gradient_descent_core.sv =====
// top level: batch gradient-descent linear regression over stored Q16.16 rows
//
//   channel   direction  word            handshake
//   s_        in         row_word_t      s_valid / s_ready
//   m_        out        result_word_t   m_valid / m_ready
//   apb       in/out     config regs     psel / penable / pwrite / pready
//
// a row word is stored as it is accepted, while the store has room; a word
// without last_row returns s_ready at once; a last_row word starts training;
//   s_ready stays low through each epoch: one setup step, the per-row steps on
//   the shared multiplier, then five serial divides and four updates
// a result word still waiting when training ends stretches the stall until it is taken
// the result word waits in its output register; new rows load while it waits
// synchronous active-low reset clears control state; the row store needs no clearing
module linear_regression_gradient_descent_core #(
    parameter int MAX_ROWS     = lrgd_pkg::MAX_ROWS_DEF,
    parameter int NUM_FEATURES = lrgd_pkg::NUM_FEATURES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // row words in
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lrgd_pkg::row_word_t    s_data,
    // result words out
    output logic                   m_valid,
    input  logic                   m_ready,
    output lrgd_pkg::result_word_t m_data,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    // register index, taken from the word address
    localparam logic REG_LR    = 1'b0;
    localparam logic REG_EPOCH = 1'b1;

    logic [lrgd_pkg::LR_W-1:0]    lr_reg;
    logic [lrgd_pkg::EPOCH_W-1:0] epoch_cnt_reg;
    logic                         cfg_wr;

    lrgd_pkg::dp_cmd_t  cmd;
    lrgd_pkg::dp_stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // config registers, written in the apb access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg        <= lrgd_pkg::LR_RESET;
            epoch_cnt_reg <= lrgd_pkg::EPOCH_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LR:    lr_reg        <= pwdata[lrgd_pkg::LR_W-1:0];
                REG_EPOCH: epoch_cnt_reg <= pwdata[lrgd_pkg::EPOCH_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[2])
            REG_LR:    prdata = 32'(lr_reg);
            REG_EPOCH: prdata = 32'(epoch_cnt_reg);
            default:   prdata = '0;
        endcase
    end

    // sequencer
    lrgd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last      (s_data.last_row),
        .m_ready     (m_ready),
        .epoch_count (epoch_cnt_reg),
        .stat        (stat),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .cmd         (cmd)
    );

    // row store, arithmetic and result register
    lrgd_datapath #(
        .MAX_ROWS     (MAX_ROWS),
        .NUM_FEATURES (NUM_FEATURES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_data        (s_data),
        .learning_rate (lr_reg),
        .stat          (stat),
        .m_data        (m_data)
    );

`include "linear_regression_gradient_descent_core_macros.svh"

    // a last row closes the input until training is done
    `LRGD_ASSERT_NEXT(ast_last_closes_input, s_valid && s_ready && s_data.last_row, !s_ready, "input open after last row")
    // divider never restarted while running
    `LRGD_ASSERT_NOW(ast_div_start_idle, cmd.div_start, !stat.div_busy, "divider restarted while busy")
    // a result only appears at the end of training
    `LRGD_ASSERT_NOW(ast_result_after_train, $rose(m_valid), $past(!s_ready), "result without training")

endmodule

// ===== tb/sv/linear_regression_gradient_descent_core_checker.sv =====
// checker for the gradient descent core: watches the row, result and register channels, predicts and compares results
`timescale 1ns / 100ps

module linear_regression_gradient_descent_core_checker #(
    parameter logic [2:0] LR_ADDR    = 3'd0,
    parameter logic [2:0] EPOCH_ADDR = 3'd4,
    parameter int         ROW_DEPTH  = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  lrgd_pkg::row_word_t    s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  lrgd_pkg::result_word_t m_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output int                     fail_count,
    output int                     results_due
);
    import lrgd_pkg::*;

    logic signed [31:0] xa_mem [ROW_DEPTH];
    logic signed [31:0] xb_mem [ROW_DEPTH];
    logic signed [31:0] xc_mem [ROW_DEPTH];
    logic signed [31:0] y_mem  [ROW_DEPTH];
    int                 rows_held;
    logic [LR_W-1:0]    step_size;
    logic [EPOCH_W-1:0] passes;
    result_word_t       trained_q [$];

    function automatic logic signed [31:0] clamp32(input logic signed [64:0] v);
        if (v[64:31] == {34{1'b0}} || v[64:31] == {34{1'b1}}) return v[31:0];
        return v[64] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

    function automatic logic signed [63:0] add_clamp64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [64:0] s;
        s = a;
        s = s + b;
        if (s > 65'sh0_7fffffff_ffffffff) return 64'sh7fffffff_ffffffff;
        if (s < -65'sh0_80000000_00000000) return 64'sh80000000_00000000;
        return s[63:0];
    endfunction

    // old - floor(avg * rate / 2^16), clamped
    function automatic logic signed [31:0] descend(input logic signed [31:0] old,
                                                   input logic signed [31:0] avg,
                                                   input logic [LR_W-1:0] rate);
        logic signed [63:0] rate_s;
        logic signed [63:0] avg_s;
        logic signed [63:0] step;
        logic signed [64:0] t;
        rate_s = {47'd0, rate};
        avg_s  = avg;
        step   = (avg_s * rate_s) >>> 16;
        t      = old;
        t      = t - step;
        return clamp32(t);
    endfunction

    function automatic result_word_t fit_rows(input int n, input logic [LR_W-1:0] rate,
                                              input logic [EPOCH_W-1:0] epochs);
        logic signed [31:0] w [3];
        logic signed [31:0] b;
        logic signed [63:0] grad [3];
        logic signed [63:0] bsum;
        logic [63:0]        sqsum;
        logic [64:0]        sqtmp;
        logic signed [63:0] p;
        logic signed [63:0] xv;
        logic signed [63:0] wv;
        logic signed [63:0] ev;
        logic signed [63:0] nn;
        logic signed [64:0] t;
        logic signed [31:0] e;
        logic signed [31:0] x [3];
        logic [63:0]        mse;
        result_word_t       r;
        w = '{0, 0, 0};
        b = 0;
        mse = 0;
        nn = n;
        for (int ep = 0; ep < epochs; ep++) begin
            grad = '{0, 0, 0};
            bsum = 0;
            sqsum = 0;
            for (int i = 0; i < n; i++) begin
                x[0] = xa_mem[i];
                x[1] = xb_mem[i];
                x[2] = xc_mem[i];
                p = b;
                for (int j = 0; j < 3; j++) begin
                    xv = x[j];
                    wv = w[j];
                    p  = p + ((xv * wv) >>> 16);
                end
                t = clamp32({p[63], p});
                t = t - y_mem[i];
                e = clamp32(t);
                ev = e;
                for (int j = 0; j < 3; j++) begin
                    xv = x[j];
                    grad[j] = add_clamp64(grad[j], xv * ev);
                end
                bsum  = add_clamp64(bsum, ev);
                sqtmp = {1'b0, sqsum} + {1'b0, 64'(ev * ev)};
                sqsum = sqtmp[64] ? '1 : sqtmp[63:0];
            end
            for (int j = 0; j < 3; j++) begin
                p    = (grad[j] / nn) >>> 16;
                w[j] = descend(w[j], clamp32({p[63], p}), rate);
            end
            p   = bsum / nn;
            b   = descend(b, clamp32({p[63], p}), rate);
            mse = (sqsum / 64'(n)) >> 16;
            if (mse > 64'hffffffff) mse = 64'hffffffff;
        end
        r.weight_a      = w[0];
        r.weight_b      = w[1];
        r.weight_c      = w[2];
        r.bias          = b;
        r.mean_sq_error = mse[31:0];
        return r;
    endfunction

    assign results_due = trained_q.size();

    always @(posedge aclk) begin
        result_word_t want;
        if (!aresetn) begin
            step_size  <= LR_RESET;
            passes     <= EPOCH_RESET;
            rows_held  <= 0;
            fail_count <= 0;
            trained_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == LR_ADDR) step_size <= pwdata[LR_W-1:0];
                if (paddr == EPOCH_ADDR) passes <= pwdata[EPOCH_W-1:0];
            end
            if (s_valid && s_ready) begin
                // a full store drops the row, but last_row still trains
                if (rows_held < ROW_DEPTH) begin
                    xa_mem[rows_held] = s_data.feature_a;
                    xb_mem[rows_held] = s_data.feature_b;
                    xc_mem[rows_held] = s_data.feature_c;
                    y_mem[rows_held]  = s_data.target;
                end
                if (s_data.last_row) begin
                    trained_q = {trained_q, fit_rows((rows_held < ROW_DEPTH) ? rows_held + 1
                                                     : rows_held, step_size, passes)};
                    rows_held <= 0;
                end else if (rows_held < ROW_DEPTH) begin
                    rows_held <= rows_held + 1;
                end
            end
            if (m_valid && m_ready) begin
                if (trained_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = trained_q.pop_front();
                    if (want !== m_data) begin
                        $display("%0t: weight_a exp %h got %h", $time,
                                 want.weight_a, m_data.weight_a);
                        $display("%0t: weight_b exp %h got %h", $time,
                                 want.weight_b, m_data.weight_b);
                        $display("%0t: weight_c exp %h got %h", $time,
                                 want.weight_c, m_data.weight_c);
                        $display("%0t: bias exp %h got %h", $time, want.bias, m_data.bias);
                        $display("%0t: mean_sq_error exp %h got %h", $time,
                                 want.mean_sq_error, m_data.mean_sq_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/linear_regression_gradient_descent_core_test.sv =====
// testbench top for the gradient descent core: stimulus, register writes and verdict
`timescale 1ns / 100ps

module linear_regression_gradient_descent_core_test;
    import lrgd_pkg::*;

    // register map
    localparam logic [2:0] LR_ADDR    = 3'd0;
    localparam logic [2:0] EPOCH_ADDR = 3'd4;
    localparam int         ROW_DEPTH  = 1024;
    localparam int         HOLD_CYCLES = 3000;
    // least number of row words for the whole run
    localparam int         ITEM_TOTAL  = 1150;
    // longest silent stretch: 4096 epochs over one row plus margin
    localparam int         QUIET_LIMIT = 4_000_000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    row_word_t    s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    result_word_t m_data;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int results_due;
    bit hold_req = 1'b0;   // asks the receiver for one long hold-off
    bit tx_busy = 1'b0;    // sender runs back to back for this batch
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    linear_regression_gradient_descent_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    linear_regression_gradient_descent_core_checker #(
        .LR_ADDR(LR_ADDR), .EPOCH_ADDR(EPOCH_ADDR), .ROW_DEPTH(ROW_DEPTH)
    ) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .results_due(results_due)
    );

    // watchdog: any handshake or register access counts as progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("linear_regression_gradient_descent_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls, sometimes none, once a long hold-off
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // two-phase register write, ending with psel low and the bus idle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_training(input logic [31:0] rate, input logic [31:0] epochs);
        reg_write(LR_ADDR, rate);
        reg_write(EPOCH_ADDR, epochs);
    endtask

    // offer one word; called and returning at a falling edge
    task automatic push_row(input row_word_t w);
        int gap;
        gap = tx_busy ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // sender pause: every expected result in, then a settle margin
    task automatic drain();
        s_valid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    default: return 32'hffffffff;
                endcase
            end
            default: return $urandom_range(0, 8 << 16) - (4 << 16);
        endcase
    endfunction

    function automatic row_word_t make_row(input bit last);
        row_word_t w;
        w.feature_a = pick_value();
        w.feature_b = pick_value();
        w.feature_c = pick_value();
        w.target    = pick_value();
        w.last_row  = last;
        return w;
    endfunction

    task automatic send_batch(input int rows);
        for (int i = 0; i < rows; i++) push_row(make_row(i == rows - 1));
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65536;
            2: return 131071;
            3: return $urandom_range(0, 131071);
            default: return $urandom_range(1, 4000);
        endcase
    endfunction

    initial begin
        row_word_t w;
        int sent;
        int rows;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, extreme rows
        w = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'h7fffffff, 1'b0};
        push_row(w);
        w = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000, 1'b0};
        push_row(w);
        w = '{32'h00010000, 32'hffff0000, 32'h7fffffff, 32'h00020000, 1'b1};
        push_row(w);
        drain();

        // zero epochs gives zero weights and zero mse
        set_training(655, 0);
        send_batch(3);
        drain();

        // no learning at all, then the largest steps
        set_training(0, 5);
        send_batch(4);
        drain();
        set_training(65536, 3);
        send_batch(2);
        drain();
        set_training(131071, 2);
        w = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b1};
        push_row(w);
        drain();

        // most epochs, single row
        set_training(655, 4096);
        send_batch(1);
        drain();

        // one epoch over a single row
        set_training(1000, 1);
        send_batch(1);
        drain();

        // receiver holds off while batches keep coming
        set_training($urandom_range(100, 3000), 1);
        hold_req = 1'b1;
        tx_busy = 1'b1;
        for (int k = 0; k < 4; k++) send_batch(3);
        tx_busy = 1'b0;
        drain();

        // random batches, mostly short runs; room left for the overflow batch
        sent = 27;
        while (sent < ITEM_TOTAL - (ROW_DEPTH + 2)) begin
            set_training(pick_rate(), ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                                    : $urandom_range(1, 4));
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            tx_busy = ($urandom_range(0, 3) == 0);
            send_batch(rows);
            tx_busy = 1'b0;
            sent += rows;
            drain();
        end

        // store overflow: both extra rows dropped, the last one still training
        set_training(655, 1);
        tx_busy = 1'b1;
        send_batch(ROW_DEPTH + 2);
        tx_busy = 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("linear_regression_gradient_descent_core test passed");
        end else begin
            $display("linear_regression_gradient_descent_core test failed");
        end
        $finish;
    end

endmodule

// ===== linear_regression_gradient_descent_core.f =====
+incdir+hdl
hdl/lrgd_pkg.sv
hdl/lrgd_div.sv
hdl/lrgd_datapath.sv
hdl/lrgd_ctrl.sv
hdl/linear_regression_gradient_descent_core.sv
tb/sv/linear_regression_gradient_descent_core_checker.sv
tb/sv/linear_regression_gradient_descent_core_test.sv
